// ===== rtl/voxel_grid_average_filter_assert.svh =====
// Assertion macros for the voxel grid average filter.
`ifndef VOXEL_GRID_AVERAGE_FILTER_ASSERT_SVH
`define VOXEL_GRID_AVERAGE_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define VGAF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define VGAF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define VGAF_ASSERT_IMPL(label, ante, cons)
`define VGAF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/vgaf_pkg.sv =====
// Shared types and constants of the voxel grid average filter.
package vgaf_pkg;
	localparam int CoordBits = 32;
	localparam int LeafBits  = 31;
	localparam int ColorBits = 24;
	localparam int ChanBits  = 8;
	localparam int OutCountBits = 16;
	localparam int IdxBits   = 12;
	localparam int GridSide  = 16;

	localparam logic [1:0] ST_NEW   = 2'd0;
	localparam logic [1:0] ST_MERGE = 2'd1;
	localparam logic [1:0] ST_OUT   = 2'd2;
	localparam logic [1:0] ST_READ  = 2'd3;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [1:0] REG_LEAF_X = 2'd0;
	localparam logic [1:0] REG_LEAF_Y = 2'd1;
	localparam logic [1:0] REG_LEAF_Z = 2'd2;

	// datapath operand selects for the shared divider
	typedef enum logic [2:0] {
		DSEL_X   = 3'd0,
		DSEL_Y   = 3'd1,
		DSEL_Z   = 3'd2,
		DSEL_MX  = 3'd3,
		DSEL_MY  = 3'd4,
		DSEL_MZ  = 3'd5,
		DSEL_CR  = 3'd6,
		DSEL_CG  = 3'd7
	} dsel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic  load_req;   // capture input request
		logic  div_start;  // start divider
		dsel_t div_sel;    // divider operands
		logic  div_blue;   // blue channel (overrides sel)
		logic  clr_step;   // clear one memory entry after reset
		logic  ram_wr;     // write RAM entry with occupied bit set
		logic  cap_rd;     // capture RAM read data
		logic  calc_idx;   // compute cell index and range check, or update a running mean
		logic  set_out;    // load output register
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic op_read;
		logic outside;
		logic hit;        // voxel already occupied
		logic has_color;
		logic clr_last;   // last entry of the clearing pass
	} sts_t;
endpackage

// ===== rtl/vgaf_ram.sv =====
// Generic single-port RAM with registered read.
module vgaf_ram #(
	parameter int Width = 32,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// write one entry and read the addressed one
	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/vgaf_div.sv =====
// Shared 33-by-32 signed restoring divider, one quotient bit per cycle.
module vgaf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] num,    // signed dividend
	input  logic [31:0] den,    // unsigned divisor, nonzero
	output logic        done,
	output logic [32:0] quo,    // signed quotient, truncated toward zero
	output logic        rem_nz
);
	logic [5:0]  cnt_q;
	logic        busy_q, neg_q, done_q;
	logic [32:0] q_q;
	logic [32:0] r_q;
	logic [31:0] d_q;
	logic [33:0] trial;

	assign trial = {r_q, q_q[32]} - {2'b0, d_q};

	// shift and subtract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[32];
			q_q   <= num[32] ? (33'd0 - num) : num;
			r_q   <= '0;
			d_q   <= den;
		end else if (busy_q) begin
			if (!trial[33]) begin
				r_q <= trial[32:0];
				q_q <= {q_q[31:0], 1'b1};
			end else begin
				r_q <= {r_q[31:0], q_q[32]};
				q_q <= {q_q[31:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign quo    = neg_q ? (33'd0 - q_q) : q_q;
	assign rem_nz = (r_q != '0);
endmodule

// ===== rtl/vgaf_ctrl.sv =====
// Controller state machine of the voxel grid average filter.
module vgaf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          out_busy,
	input  vgaf_pkg::sts_t sts,
	output vgaf_pkg::cmd_t cmd
);
	import vgaf_pkg::*;

	typedef enum logic [12:0] {
		S_CLR   = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_DIVS  = 13'b0000000000100,
		S_DIVW  = 13'b0000000001000,
		S_INDEX = 13'b0000000010000,
		S_RD    = 13'b0000000100000,
		S_RDW   = 13'b0000001000000,
		S_CAP   = 13'b0000010000000,
		S_MDIVS = 13'b0000100000000,
		S_MDIVW = 13'b0001000000000,
		S_WR    = 13'b0010000000000,
		S_OUT   = 13'b0100000000000,
		S_RES   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic [2:0] step_q, step_d;

	assign in_stall = (state_q != S_IDLE);

	// sequence one request
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		cmd.div_sel = dsel_t'(step_q);
		cmd.div_blue = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d = S_DIVS;
					step_d  = 3'd0;
				end
			end
			S_DIVS: begin
				if (sts.op_read) begin
					state_d = S_RD;
				end else begin
					cmd.div_start = 1'b1;
					state_d = S_DIVW;
				end
			end
			S_DIVW: begin
				if (sts.div_done) begin
					cmd.calc_idx = 1'b1;
					if (step_q == 3'd2) begin
						state_d = S_INDEX;
					end else begin
						step_d  = step_q + 3'd1;
						state_d = S_DIVS;
					end
				end
			end
			S_INDEX: begin
				state_d = sts.outside ? S_OUT : S_RD;
			end
			S_RD: begin
				state_d = S_RDW;
			end
			S_RDW: begin
				state_d = S_CAP;
			end
			S_CAP: begin
				cmd.cap_rd = 1'b1;
				if (sts.op_read || !sts.hit) begin
					state_d = sts.op_read ? S_OUT : S_WR;
				end else begin
					step_d  = 3'd3;
					state_d = S_MDIVS;
				end
			end
			S_MDIVS: begin
				cmd.div_start = 1'b1;
				cmd.div_blue  = (step_q == 3'd0);
				cmd.div_sel   = (step_q == 3'd0) ? DSEL_CG : dsel_t'(step_q);
				state_d = S_MDIVW;
			end
			S_MDIVW: begin
				cmd.div_blue = (step_q == 3'd0);
				cmd.div_sel  = (step_q == 3'd0) ? DSEL_CG : dsel_t'(step_q);
				if (sts.div_done) begin
					cmd.calc_idx = 1'b1;
					if (step_q == 3'd0 || (step_q == 3'd5 && !sts.has_color)) begin
						state_d = S_WR;
					end else begin
						step_d  = (step_q == 3'd7) ? 3'd0 : step_q + 3'd1;
						state_d = S_MDIVS;
					end
				end
			end
			S_WR: begin
				cmd.ram_wr = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_busy) begin
					cmd.set_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end
endmodule

// ===== rtl/vgaf_dp.sv =====
// Datapath: request registers, divider, voxel memory and result register.
module vgaf_dp #(
	parameter int CountBits = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vgaf_pkg::cmd_t              cmd,
	output vgaf_pkg::sts_t              sts,
	input  logic [vgaf_pkg::LeafBits-1:0] leaf_x,
	input  logic [vgaf_pkg::LeafBits-1:0] leaf_y,
	input  logic [vgaf_pkg::LeafBits-1:0] leaf_z,
	input  logic                        in_op,
	input  logic signed [31:0]          in_x,
	input  logic signed [31:0]          in_y,
	input  logic signed [31:0]          in_z,
	input  logic [23:0]                 in_color,
	input  logic                        in_has_color,
	input  logic [11:0]                 in_read_index,
	output logic [1:0]                  o_status,
	output logic [11:0]                 o_index,
	output logic                        o_occupied,
	output logic [15:0]                 o_count,
	output logic [31:0]                 o_mx,
	output logic [31:0]                 o_my,
	output logic [31:0]                 o_mz,
	output logic [23:0]                 o_color
);
	import vgaf_pkg::*;

	localparam int SideBits = $clog2(GridSide);
	localparam int Cells    = GridSide * GridSide * GridSide;
	localparam int AddrBits = $clog2(Cells);
	localparam logic [CountBits-1:0] CountMax = '1;
	// occupied bit on top, then count, means and color
	localparam int RamW = 1 + CountBits + 3 * CoordBits + ColorBits;
	localparam int CntTop = RamW - 2;

	logic        op_q, hc_q;
	logic [31:0] x_q, y_q, z_q;
	logic [23:0] col_q;
	logic [11:0] ri_q;
	logic [SideBits-1:0] cx_q, cy_q, cz_q;
	logic        outside_q;
	logic [AddrBits-1:0] clr_addr_q;
	logic        hit_q;
	logic [CountBits-1:0] n_q;
	logic [31:0] mx_q, my_q, mz_q;
	logic [23:0] mc_q;

	// divider operand selection
	logic [32:0] num;
	logic [31:0] den;
	logic [7:0]  ca, cb;
	logic        div_done, rem_nz;
	logic [32:0] quo;

	always_comb begin
		ca = mc_q[23:16];
		cb = col_q[23:16];
		if (cmd.div_blue) begin
			ca = mc_q[7:0];
			cb = col_q[7:0];
		end else if (cmd.div_sel == DSEL_CG) begin
			ca = mc_q[15:8];
			cb = col_q[15:8];
		end
		num = {x_q[31], x_q};
		den = {1'b0, (leaf_x == '0) ? 31'd1 : leaf_x};
		case (cmd.div_sel)
			DSEL_X: begin
				num = {x_q[31], x_q};
				den = {1'b0, (leaf_x == '0) ? 31'd1 : leaf_x};
			end
			DSEL_Y: begin
				num = {y_q[31], y_q};
				den = {1'b0, (leaf_y == '0) ? 31'd1 : leaf_y};
			end
			DSEL_Z: begin
				num = {z_q[31], z_q};
				den = {1'b0, (leaf_z == '0) ? 31'd1 : leaf_z};
			end
			DSEL_MX: begin
				num = {x_q[31], x_q} - {mx_q[31], mx_q};
				den = 32'(n_q);
			end
			DSEL_MY: begin
				num = {y_q[31], y_q} - {my_q[31], my_q};
				den = 32'(n_q);
			end
			DSEL_MZ: begin
				num = {z_q[31], z_q} - {mz_q[31], mz_q};
				den = 32'(n_q);
			end
			default: begin
				num = {25'd0, cb} - {25'd0, ca};
				den = 32'(n_q);
			end
		endcase
	end

	vgaf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(num), .den(den),
		.done(div_done), .quo(quo), .rem_nz(rem_nz)
	);

	// floored quotient and range check
	logic [32:0] fq;
	logic        fq_out;
	assign fq = quo - {32'd0, (rem_nz && num[32])};
	assign fq_out = fq[32] || (fq[31:0] >= 32'(GridSide));

	logic [AddrBits-1:0] idx;
	assign idx = op_q ? ri_q[AddrBits-1:0] : {cz_q, cy_q, cx_q};
	logic ri_in;
	assign ri_in = (32'(ri_q) < 32'(Cells));

	// voxel memory, cleared entry by entry after reset
	logic [RamW-1:0] wdata, rdata, ram_wdata;
	logic [AddrBits-1:0] ram_addr;
	logic ram_we;
	logic hit_now;
	assign wdata     = {1'b1, n_q, mx_q, my_q, mz_q, mc_q};
	assign ram_wdata = cmd.clr_step ? '0 : wdata;
	assign ram_addr  = cmd.clr_step ? clr_addr_q : idx;
	assign ram_we    = cmd.ram_wr || cmd.clr_step;
	assign hit_now   = rdata[RamW-1] && (!op_q || ri_in);
	vgaf_ram #(.Width(RamW), .Depth(Cells)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(rdata)
	);

	// capture request
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q  <= in_op;
			x_q   <= in_x;
			y_q   <= in_y;
			z_q   <= in_z;
			col_q <= in_color;
			hc_q  <= in_has_color;
			ri_q  <= in_read_index;
			outside_q <= 1'b0;
		end
		// coordinate cells and running-mean results
		if (cmd.calc_idx) begin
			if (cmd.div_blue)
				mc_q[7:0] <= ca + quo[7:0];
			else case (cmd.div_sel)
				DSEL_X: begin
					cx_q <= fq[SideBits-1:0];
					outside_q <= fq_out;
				end
				DSEL_Y: begin
					cy_q <= fq[SideBits-1:0];
					outside_q <= outside_q | fq_out;
				end
				DSEL_Z: begin
					cz_q <= fq[SideBits-1:0];
					outside_q <= outside_q | fq_out;
				end
				DSEL_MX: mx_q <= mx_q + quo[31:0];
				DSEL_MY: my_q <= my_q + quo[31:0];
				DSEL_MZ: mz_q <= mz_q + quo[31:0];
				DSEL_CR: mc_q[23:16] <= ca + quo[7:0];
				default: mc_q[15:8] <= ca + quo[7:0];
			endcase
		end
		// load stored voxel, or start a new one from the request
		if (cmd.cap_rd) begin
			if (!op_q && !hit_now) begin
				n_q  <= CountBits'(1);
				mx_q <= x_q;
				my_q <= y_q;
				mz_q <= z_q;
				mc_q <= hc_q ? col_q : '0;
			end else begin
				n_q  <= (rdata[CntTop -: CountBits] != CountMax && !op_q)
					? rdata[CntTop -: CountBits] + CountBits'(1)
					: rdata[CntTop -: CountBits];
				mx_q <= rdata[3*CoordBits+ColorBits-1 -: CoordBits];
				my_q <= rdata[2*CoordBits+ColorBits-1 -: CoordBits];
				mz_q <= rdata[CoordBits+ColorBits-1 -: CoordBits];
				mc_q <= rdata[ColorBits-1:0];
			end
		end
	end

	// clearing pass address and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			hit_q      <= 1'b0;
		end else begin
			if (cmd.clr_step)
				clr_addr_q <= clr_addr_q + AddrBits'(1);
			if (cmd.cap_rd)
				hit_q <= hit_now;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.set_out) begin
			o_index    <= '0;
			o_occupied <= 1'b0;
			o_count    <= '0;
			o_mx <= '0;
			o_my <= '0;
			o_mz <= '0;
			o_color <= '0;
			if (op_q) begin
				o_status <= ST_READ;
				o_index  <= ri_q;
			end else if (outside_q) begin
				o_status <= ST_OUT;
			end else begin
				o_status <= hit_q ? ST_MERGE : ST_NEW;
				o_index  <= 12'(idx);
			end
			if ((op_q && hit_q) || (!op_q && !outside_q)) begin
				o_occupied <= 1'b1;
				o_count <= OutCountBits'(n_q);
				o_mx <= mx_q;
				o_my <= my_q;
				o_mz <= mz_q;
				o_color <= mc_q;
			end
		end
	end

	assign sts.div_done  = div_done;
	assign sts.op_read   = op_q;
	assign sts.outside   = outside_q;
	assign sts.hit       = hit_now;
	assign sts.has_color = hc_q;
	assign sts.clr_last  = (clr_addr_q == AddrBits'(Cells - 1));
endmodule

// ===== rtl/voxel_grid_average_filter.sv =====
// Voxel grid average filter, top level.
// After reset the voxel memory is cleared one entry per cycle, all 4096 entries, with
// the input stalled. Then one request at a time, each division running on the shared
// bit-serial divider. An add takes 3 divisions plus memory access; a point outside the
// grid takes the 3 divisions only; a merge adds 3 divisions, or 6 with color; a read
// takes no division, only the memory access.
// The result waits in an output register until taken; the next request is taken
// while the previous result is still held there, up to the point of loading a new
// result.
module voxel_grid_average_filter #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic [23:0] point_color,
	input  logic        has_color,
	input  logic [11:0] read_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [11:0] voxel_index,
	output logic        occupied,
	output logic [15:0] point_count,
	output logic signed [31:0] mean_x,
	output logic signed [31:0] mean_y,
	output logic signed [31:0] mean_z,
	output logic [23:0] mean_color,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import vgaf_pkg::*;
	`include "voxel_grid_average_filter_assert.svh"

	logic [LeafBits-1:0] leaf_x_q, leaf_y_q, leaf_z_q;
	logic out_valid_q;
	cmd_t cmd;
	sts_t sts;
	logic out_busy;

	assign cfg_ready = 1'b1;
	assign out_busy  = out_valid_q && out_stall;

	// write leaf sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_x_q <= LeafBits'(6554);
			leaf_y_q <= LeafBits'(6554);
			leaf_z_q <= LeafBits'(6554);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEAF_X: leaf_x_q <= cfg_data[LeafBits-1:0];
				REG_LEAF_Y: leaf_y_q <= cfg_data[LeafBits-1:0];
				REG_LEAF_Z: leaf_z_q <= cfg_data[LeafBits-1:0];
				default: ;
			endcase
		end
	end

	// hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.set_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end
	assign out_valid = out_valid_q;

	vgaf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_busy(out_busy), .sts(sts), .cmd(cmd)
	);

	vgaf_dp #(.CountBits(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.leaf_x(leaf_x_q), .leaf_y(leaf_y_q), .leaf_z(leaf_z_q),
		.in_op(operation), .in_x(coord_x), .in_y(coord_y), .in_z(coord_z),
		.in_color(point_color), .in_has_color(has_color), .in_read_index(read_index),
		.o_status(status), .o_index(voxel_index), .o_occupied(occupied),
		.o_count(point_count), .o_mx(mean_x), .o_my(mean_y), .o_mz(mean_z),
		.o_color(mean_color)
	);

	`VGAF_ASSERT_IMPL(a_load_idle, cmd.load_req, !in_stall)
	`VGAF_ASSERT_IMPL(a_no_overwrite, cmd.set_out, !out_busy)
	`VGAF_ASSERT_NEXT(a_out_after_set, cmd.set_out, out_valid)
	`VGAF_ASSERT_IMPL(a_read_no_write, cmd.ram_wr, !sts.op_read && !sts.outside)
endmodule
